// ===== hdl/u8u2_pkg.sv =====
// Shared types and constants for the UTF-8 to UCS-2 decoder.
package u8u2_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned UnitW  = 16;
	localparam int unsigned CountW = 24;
	localparam int unsigned PendW  = 2;
	localparam int unsigned ApbW   = 32;
	localparam int unsigned AddrW  = 3;

	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

	// Register indexes, taken from the word address of the configuration port.
	localparam logic REG_UNIT_CAPACITY = 1'b0;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_LEAD = 3'd1,
		ST_BAD_CONT = 3'd2,
		ST_TRUNC    = 3'd3,
		ST_OVER_CAP = 3'd4
	} status_t;

	typedef struct packed {
		logic [UnitW-1:0]  code_unit;
		logic              has_unit;
		logic              msg_done;
		status_t           status;
		logic [CountW-1:0] unit_total;
	} result_t;

endpackage

// ===== hdl/u8u2_if.sv =====
// Stream interfaces for the byte input and the result output.
interface u8u2_in_if;
	import u8u2_pkg::*;

	logic             valid;
	logic             ready;
	logic [ByteW-1:0] in_byte;
	logic             in_last;

	modport source (output valid, in_byte, in_last, input ready);
	modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface u8u2_out_if;
	import u8u2_pkg::*;

	logic              valid;
	logic              ready;
	logic [UnitW-1:0]  code_unit;
	logic              has_unit;
	logic              msg_done;
	status_t           status;
	logic [CountW-1:0] unit_total;

	modport source (output valid, code_unit, has_unit, msg_done, status, unit_total,
		input ready);
	modport sink   (input valid, code_unit, has_unit, msg_done, status, unit_total,
		output ready);
endinterface

// ===== hdl/u8u2_cfg.sv =====
// APB-style register block holding the per-message unit capacity.
module u8u2_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [u8u2_pkg::AddrW-1:0]  paddr,
	input  logic [u8u2_pkg::ApbW-1:0]   pwdata,
	output logic [u8u2_pkg::ApbW-1:0]   prdata,
	output logic                        pready,
	output logic [u8u2_pkg::CountW-1:0] unit_capacity
);
	import u8u2_pkg::*;

	logic [CountW-1:0] cap_q;
	logic              wr_cap;

	assign pready = 1'b1;
	assign wr_cap = psel && penable && pwrite && pready &&
		(paddr[AddrW-1] == REG_UNIT_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CountMax;
		end else if (wr_cap) begin
			cap_q <= pwdata[CountW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[AddrW-1] == REG_UNIT_CAPACITY) begin
			prdata = {{(ApbW-CountW){1'b0}}, cap_q};
		end
	end

	assign unit_capacity = cap_q;
endmodule

// ===== hdl/u8u2_core.sv =====
// Decode stage: message state and the combinational per-byte update.
module u8u2_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [u8u2_pkg::ByteW-1:0]  in_byte,
	input  logic                        in_last,
	input  logic [u8u2_pkg::CountW-1:0] unit_capacity,
	output logic                        produce,
	output u8u2_pkg::result_t           result
);
	import u8u2_pkg::*;

	logic [PendW-1:0]  pend_q, pend_d;
	logic [UnitW-1:0]  part_q, part_d;
	logic [CountW-1:0] units_q, units_d;
	status_t           err_q, err_d;

	logic              dec_err_q;
	logic              complete;
	logic              emit;
	logic [UnitW-1:0]  value;

	assign dec_err_q = (err_q == ST_BAD_LEAD) || (err_q == ST_BAD_CONT) ||
		(err_q == ST_TRUNC);

	always_comb begin
		pend_d   = pend_q;
		part_d   = part_q;
		units_d  = units_q;
		err_d    = err_q;
		complete = 1'b0;
		emit     = 1'b0;
		value    = '0;

		if (!dec_err_q) begin
			if (pend_q == '0) begin
				priority if (!in_byte[7]) begin
					complete = 1'b1;
					value    = {{(UnitW-ByteW){1'b0}}, in_byte};
				end else if (in_byte[7:5] == 3'b110) begin
					part_d = {5'b0, in_byte[4:0], 6'b0};
					pend_d = 2'd1;
				end else if (in_byte[7:4] == 4'b1110) begin
					part_d = {in_byte[3:0], 12'b0};
					pend_d = 2'd2;
				end else begin
					err_d  = ST_BAD_LEAD;
					pend_d = '0;
					part_d = '0;
				end
			end else if (in_byte[7:6] != 2'b10) begin
				err_d  = ST_BAD_CONT;
				pend_d = '0;
				part_d = '0;
			end else if (pend_q == 2'd2) begin
				pend_d = 2'd1;
				part_d = part_q | {4'b0, in_byte[5:0], 6'b0};
			end else begin
				complete = 1'b1;
				value    = part_q | {10'b0, in_byte[5:0]};
				pend_d   = '0;
				part_d   = '0;
			end
		end

		// A completed unit is counted, saturating at CountMax; it is passed on only while the
		// message is clean and below capacity.
		if (complete) begin
			if (units_q >= unit_capacity) begin
				if (err_q == ST_OK) begin
					err_d = ST_OVER_CAP;
				end
			end else begin
				emit = (err_q == ST_OK);
			end
			if (units_q != CountMax) begin
				units_d = units_q + 1'b1;
			end
		end

		if (in_last && (pend_d != '0) && (err_d == ST_OK || err_d == ST_OVER_CAP)) begin
			err_d = ST_TRUNC;
		end

		produce           = emit || in_last;
		result.code_unit  = emit ? value : '0;
		result.has_unit   = emit;
		result.msg_done   = in_last;
		result.status     = in_last ? err_d : ST_OK;
		result.unit_total = in_last ? units_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			part_q  <= '0;
			units_q <= '0;
			err_q   <= ST_OK;
		end else if (step) begin
			if (in_last) begin
				pend_q  <= '0;
				part_q  <= '0;
				units_q <= '0;
				err_q   <= ST_OK;
			end else begin
				pend_q  <= pend_d;
				part_q  <= part_d;
				units_q <= units_d;
				err_q   <= err_d;
			end
		end
	end
endmodule

// ===== hdl/utf8_to_ucs2_decoder.sv =====
// Top level of the UTF-8 to UCS-2 decoder.
//
//   channel   dir   handshake        payload
//   in_ch     in    valid / ready    in_byte, in_last
//   out_ch    out   valid / ready    code_unit, has_unit, msg_done, status, unit_total
//   apb       in    psel / penable   paddr, pwdata, prdata (unit_capacity at 0x0)
//
// One byte per cycle while the output is not stalled: a byte sits in the input
// register, is decoded combinationally against the message state and its result,
// if any, lands in the output register. Reset clears the message state and sets
// unit_capacity to its maximum. A stalled output holds the output register and
// the input register still takes one more request behind it.
module utf8_to_ucs2_decoder (
	input  logic                       clk,
	input  logic                       arst_n,
	u8u2_in_if.sink                    in_ch,
	u8u2_out_if.source                 out_ch,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [u8u2_pkg::AddrW-1:0] paddr,
	input  logic [u8u2_pkg::ApbW-1:0]  pwdata,
	output logic [u8u2_pkg::ApbW-1:0]  prdata,
	output logic                       pready
);
	import u8u2_pkg::*;

	logic              valid_s1;
	logic [ByteW-1:0]  byte_s1;
	logic              last_s1;
	logic              valid_s2;
	result_t           res_s2;

	logic [CountW-1:0] unit_capacity;
	logic              produce;
	result_t           result;
	logic              step;
	logic              take_in;

	u8u2_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.unit_capacity (unit_capacity)
	);

	u8u2_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.in_byte       (byte_s1),
		.in_last       (last_s1),
		.unit_capacity (unit_capacity),
		.produce       (produce),
		.result        (result)
	);

	// A byte that yields no result can retire even while the output is blocked.
	assign step        = valid_s1 && (!produce || !valid_s2 || out_ch.ready);
	assign take_in     = in_ch.valid && in_ch.ready;
	assign in_ch.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step && produce) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && produce) begin
			res_s2 <= result;
		end
	end

	assign out_ch.valid      = valid_s2;
	assign out_ch.code_unit  = res_s2.code_unit;
	assign out_ch.has_unit   = res_s2.has_unit;
	assign out_ch.msg_done   = res_s2.msg_done;
	assign out_ch.status     = res_s2.status;
	assign out_ch.unit_total = res_s2.unit_total;
endmodule
